// ----- rtl/rrf_pkg.sv -----
package rrf_pkg;

  localparam int unsigned PacketBytesDefault = 64;
  localparam int unsigned CmdDepth           = 4;
  localparam logic [15:0] MaxReadSizeReset   = 16'hFFF0;

  localparam logic [7:0] ChStx = 8'h02;
  localparam logic [7:0] ChEtx = 8'h03;
  localparam logic [7:0] ChRs  = 8'h1E;

  typedef enum logic [1:0] {
    CmdStart,
    CmdError,
    CmdData,
    CmdDataLast
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [15:0] len;
    logic [7:0]  data;
    logic [7:0]  sum;
  } cmd_t;

  localparam logic [2:0] StepHdrLast = 3'd7;
  localparam logic [2:0] StepData    = 3'd0;
  localparam logic [2:0] StepSum     = 3'd1;
  localparam logic [2:0] StepEtx     = 3'd2;

  function automatic logic [7:0] hdr_byte(input logic [2:0] step, input logic [15:0] len);
    logic [7:0] b;
    case (step)
      3'd0:    b = ChStx;
      3'd1:    b = 8'h52;
      3'd2:    b = 8'h45;
      3'd3:    b = 8'h41;
      3'd4:    b = 8'h44;
      3'd5:    b = ChRs;
      3'd6:    b = len[15:8];
      default: b = len[7:0];
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/rrf_front.sv -----
module rrf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic          accept_i,
  input  logic          req_type_i,
  input  logic [15:0]   read_length_i,
  input  logic [7:0]    data_byte_i,
  output logic          cmd_push_o,
  output rrf_pkg::cmd_t cmd_o
);
  import rrf_pkg::*;

  logic [15:0] max_size_q;
  logic        open_q, open_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  sum_add;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= MaxReadSizeReset;
    end else if (cfg_we_i) begin
      max_size_q <= cfg_wdata_i;
    end
  end

  assign sum_add = sum_q + data_byte_i;

  always_comb begin
    open_d     = open_q;
    left_d     = left_q;
    sum_d      = sum_q;
    cmd_push_o = 1'b0;
    cmd_o.kind = CmdData;
    cmd_o.len  = read_length_i;
    cmd_o.data = data_byte_i;
    cmd_o.sum  = sum_add;
    if (accept_i) begin
      if (!req_type_i) begin
        cmd_push_o = 1'b1;
        if (read_length_i == 16'd0 || read_length_i > max_size_q) begin
          cmd_o.kind = CmdError;
          open_d     = 1'b0;
          left_d     = '0;
          sum_d      = '0;
        end else begin
          cmd_o.kind = CmdStart;
          open_d     = 1'b1;
          left_d     = read_length_i;
          sum_d      = read_length_i[15:8] + read_length_i[7:0];
        end
      end else if (open_q) begin
        cmd_push_o = 1'b1;
        left_d     = left_q - 16'd1;
        if (left_q == 16'd1) begin
          cmd_o.kind = CmdDataLast;
          open_d     = 1'b0;
          sum_d      = '0;
        end else begin
          sum_d      = sum_add;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= '0;
      sum_q  <= '0;
    end else begin
      open_q <= open_d;
      left_q <= left_d;
      sum_q  <= sum_d;
    end
  end

endmodule

// ----- rtl/rrf_cmd_fifo.sv -----
module rrf_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rrf_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output rrf_pkg::cmd_t data_o
);
  import rrf_pkg::*;

  localparam int unsigned PtrW = $clog2(CmdDepth);
  localparam int unsigned CntW = $clog2(CmdDepth + 1);

  cmd_t            mem_q [CmdDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(CmdDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(CmdDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(CmdDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

// ----- rtl/rrf_back.sv -----
module rrf_back #(
  parameter int unsigned PacketBytes = rrf_pkg::PacketBytesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  rrf_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte_o,
  output logic          packet_end_o,
  output logic          empty_packet_o,
  output logic          length_error_o,
  output logic          last_o
);
  import rrf_pkg::*;

  localparam int unsigned FillW = $clog2(PacketBytes);

  logic [FillW-1:0] fill_q, fill_d, fill_cur;
  logic [2:0]       step_q, step_d;
  logic             wrap, adv, fire;
  logic             out_valid_q;
  logic [7:0]       r_byte, byte_q;
  logic             r_pend, r_empty, r_err, r_last;
  logic             pend_q, empty_pkt_q, err_q, last_q;

  assign adv  = !out_valid_q || pop;
  assign fire = cmd_valid_i && adv;

  assign fill_cur = (cmd_i.kind == CmdStart && step_q == '0) ? '0 : fill_q;
  assign wrap     = (fill_cur == FillW'(PacketBytes - 1));

  always_comb begin
    r_byte  = '0;
    r_pend  = wrap;
    r_empty = 1'b0;
    r_err   = 1'b0;
    r_last  = 1'b0;
    fill_d  = wrap ? '0 : fill_cur + FillW'(1);
    case (cmd_i.kind)
      CmdStart: begin
        r_byte = hdr_byte(step_q, cmd_i.len);
        r_last = (step_q == StepHdrLast);
      end
      CmdError: begin
        r_pend = 1'b0;
        r_err  = 1'b1;
        r_last = 1'b1;
        fill_d = '0;
      end
      CmdData: begin
        r_byte = cmd_i.data;
        r_last = 1'b1;
      end
      CmdDataLast: begin
        case (step_q)
          StepData: r_byte = cmd_i.data;
          StepSum:  r_byte = cmd_i.sum;
          StepEtx: begin
            r_byte = ChEtx;
            r_pend = 1'b1;
            r_last = !wrap;
            fill_d = '0;
          end
          default: begin
            // zero-length packet marker after a boundary-aligned reply
            r_pend  = 1'b0;
            r_empty = 1'b1;
            r_last  = 1'b1;
            fill_d  = fill_q;
          end
        endcase
      end
      default: begin
        r_last = 1'b1;
      end
    endcase
    step_d = r_last ? '0 : step_q + 3'd1;
  end

  assign cmd_pop_o = fire && r_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        fill_q      <= fill_d;
        step_q      <= step_d;
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q      <= r_byte;
      pend_q      <= r_pend;
      empty_pkt_q <= r_empty;
      err_q       <= r_err;
      last_q      <= r_last;
    end
  end

  assign empty          = !out_valid_q;
  assign out_byte_o     = byte_q;
  assign packet_end_o   = pend_q;
  assign empty_packet_o = empty_pkt_q;
  assign length_error_o = err_q;
  assign last_o         = last_q;

  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && err_q |-> last_q && !pend_q && byte_q == 8'd0)
    else $error("error result not a lone zero result");

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && empty_pkt_q |-> last_q && !pend_q && byte_q == 8'd0)
    else $error("zero-length marker malformed");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(PacketBytes - 1))
    else $error("packet fill out of range");

  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> out_valid_q && last_q)
    else $error("command retired without final result");

endmodule

// ----- rtl/read_response_framer_top.sv -----
// Read-reply framer. Each accepted start item emits STX "READ" RS and the
// two length bytes (eight results), a bad length one error result; each data
// item of an open frame emits one byte, and the frame's last data byte also
// emits the checksum and ETX, plus a zero-length packet marker when ETX closes
// a packet exactly. Input items are taken one per cycle while not full into a
// four-entry command queue, so push sees full only when the result side has
// fallen four commands behind; results leave at one per cycle while pop is
// held, from the single output register of the expansion stage; a start
// item yields eight results and a final data byte three or four.
module read_response_framer_top #(
  parameter int unsigned PacketBytes = rrf_pkg::PacketBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic        req_type_i,
  input  logic [15:0] read_length_i,
  input  logic [7:0]  data_byte_i,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  out_byte_o,
  output logic        packet_end_o,
  output logic        empty_packet_o,
  output logic        length_error_o,
  output logic        last_o
);
  import rrf_pkg::*;

  logic accept;
  logic cmd_push, cmd_valid, cmd_pop;
  cmd_t cmd_in, cmd_out;

  assign accept = push && !full;

  rrf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .req_type_i    (req_type_i),
    .read_length_i (read_length_i),
    .data_byte_i   (data_byte_i),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in)
  );

  rrf_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  rrf_back #(
    .PacketBytes (PacketBytes)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd_out),
    .cmd_pop_o      (cmd_pop),
    .pop            (pop),
    .empty          (empty),
    .out_byte_o     (out_byte_o),
    .packet_end_o   (packet_end_o),
    .empty_packet_o (empty_packet_o),
    .length_error_o (length_error_o),
    .last_o         (last_o)
  );

endmodule

// ----- test/tb_read_response_framer_top.sv -----
module tb_read_response_framer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rrf_pkg::*;

  localparam int unsigned LinkPacketBytes = PacketBytesDefault;
  localparam int unsigned ItemTarget      = 460;
  localparam int unsigned DrainCycles     = 24;
  localparam int unsigned HoldCycles      = 300;
  localparam logic [31:0] ReadTag         = "READ";

  typedef enum logic {
    ReqStart = 1'b0,
    ReqData  = 1'b1
  } req_kind_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
    logic       empty_packet;
    logic       length_error;
    logic       last_flag;
  } link_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        push;
  logic        full;
  logic        req_type_i;
  logic [15:0] read_length_i;
  logic [7:0]  data_byte_i;
  logic        pop;
  logic        empty;
  logic [7:0]  out_byte_o;
  logic        packet_end_o;
  logic        empty_packet_o;
  logic        length_error_o;
  logic        last_o;

  // predictor state
  logic [15:0] read_limit;
  logic        frame_active;
  logic [15:0] data_remaining;
  logic [7:0]  frame_sum;
  logic [8:0]  link_fill;

  link_result_t pending_results[$];
  link_result_t next_expected;

  int unsigned errors;
  int unsigned items_sent;
  int unsigned pop_hold_left;
  int unsigned pop_stall_left;
  bit          idle_on;

  read_response_framer_top #(
    .PacketBytes(LinkPacketBytes)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .req_type_i    (req_type_i),
    .read_length_i (read_length_i),
    .data_byte_i   (data_byte_i),
    .pop           (pop),
    .empty         (empty),
    .out_byte_o    (out_byte_o),
    .packet_end_o  (packet_end_o),
    .empty_packet_o(empty_packet_o),
    .length_error_o(length_error_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic link_result_t link_byte(logic [7:0] b);
    link_result_t r;
    r = '{out_byte: b, packet_end: 1'b0, empty_packet: 1'b0,
          length_error: 1'b0, last_flag: 1'b0};
    link_fill = link_fill + 9'd1;
    if (link_fill >= LinkPacketBytes) begin
      link_fill    = '0;
      r.packet_end = 1'b1;
    end
    return r;
  endfunction

  // expected link bytes caused by one accepted transaction
  task automatic frame_reply(req_kind_e kind, logic [15:0] len, logic [7:0] data);
    link_result_t burst[$];
    int k;
    if (kind == ReqStart) begin
      frame_active   = 1'b0;
      data_remaining = '0;
      frame_sum      = '0;
      link_fill      = '0;
      if (len == 16'd0 || len > read_limit) begin
        burst.push_back('{out_byte: 8'h00, packet_end: 1'b0, empty_packet: 1'b0,
                          length_error: 1'b1, last_flag: 1'b0});
      end else begin
        burst.push_back(link_byte(ChStx));
        burst.push_back(link_byte(ReadTag[31:24]));
        burst.push_back(link_byte(ReadTag[23:16]));
        burst.push_back(link_byte(ReadTag[15:8]));
        burst.push_back(link_byte(ReadTag[7:0]));
        burst.push_back(link_byte(ChRs));
        burst.push_back(link_byte(len[15:8]));
        burst.push_back(link_byte(len[7:0]));
        frame_sum      = len[15:8] + len[7:0];
        data_remaining = len;
        frame_active   = 1'b1;
      end
    end else if (frame_active) begin
      frame_sum = frame_sum + data;
      burst.push_back(link_byte(data));
      data_remaining = data_remaining - 16'd1;
      if (data_remaining == 16'd0) begin
        burst.push_back(link_byte(frame_sum));
        burst.push_back(link_byte(ChEtx));
        if (link_fill == 9'd0) begin
          burst.push_back('{out_byte: 8'h00, packet_end: 1'b0, empty_packet: 1'b1,
                            length_error: 1'b0, last_flag: 1'b0});
        end else begin
          k = burst.size() - 1;
          burst[k].packet_end = 1'b1;
          link_fill = '0;
        end
        frame_active = 1'b0;
        frame_sum    = '0;
      end
    end
    if (burst.size() > 0) begin
      k = burst.size() - 1;
      burst[k].last_flag = 1'b1;
      items_sent++;
    end
    foreach (burst[i]) begin
      pending_results.push_back(burst[i]);
    end
  endtask

  // called at a clock edge, returns at the edge that takes the transaction
  task automatic send_item(req_kind_e kind, logic [15:0] len, logic [7:0] data);
    int unsigned gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    req_type_i    <= kind;
    read_length_i <= len;
    data_byte_i   <= data;
    do @(posedge clk_i); while (full);
    frame_reply(kind, len, data);
  endtask

  task automatic send_frame(logic [15:0] len, int unsigned count);
    send_item(ReqStart, len, 8'($urandom));
    repeat (count) send_item(ReqData, 16'($urandom), 8'($urandom));
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    read_limit  = value;
  endtask

  function automatic logic [15:0] pick_length();
    int unsigned r;
    logic [15:0] len;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      len = 16'($urandom_range(1, 12));
    end else if (r < 95) begin
      len = 16'($urandom_range(13, 70));
    end else begin
      len = 16'($urandom_range(100, 130));
    end
    if (len > read_limit) begin
      len = 16'($urandom_range(1, read_limit));
    end
    return len;
  endfunction

  task automatic test_length_limits();
    send_item(ReqStart, 16'd0, 8'($urandom));
    send_item(ReqData, 16'hFFFF, 8'hFF);
    send_item(ReqStart, MaxReadSizeReset, 8'hFF);
    send_item(ReqData, 16'h0000, 8'h00);
    send_item(ReqStart, MaxReadSizeReset + 16'd1, 8'h00);
    send_item(ReqData, 16'h0001, 8'h5A);
    send_item(ReqStart, 16'd1, 8'h00);
    send_item(ReqData, 16'h0000, 8'hFF);
    send_item(ReqStart, 16'd3, 8'hFF);
    send_item(ReqData, 16'hFFFF, 8'h00);
    send_item(ReqData, 16'hFFFF, 8'hA5);
    send_item(ReqData, 16'hFFFF, 8'h5A);
  endtask

  task automatic test_limit_extremes();
    wait_idle();
    write_limit(16'hFFFF);
    send_item(ReqStart, 16'hFFFF, 8'h00);
    send_item(ReqData, 16'h0000, 8'h80);
    send_item(ReqStart, 16'd2, 8'h00);
    send_item(ReqData, 16'h0000, 8'h7F);
    send_item(ReqData, 16'h0000, 8'h01);
    wait_idle();
    write_limit(16'd1);
    send_item(ReqStart, 16'd1, 8'h00);
    send_item(ReqData, 16'h0000, 8'h55);
    send_item(ReqStart, 16'd2, 8'h00);
    wait_idle();
    write_limit(16'd0);
    send_item(ReqStart, 16'd1, 8'h00);
    send_item(ReqStart, 16'hFFFF, 8'h00);
    send_item(ReqData, 16'h0000, 8'hAA);
    wait_idle();
    write_limit(MaxReadSizeReset);
  endtask

  // frame lengths that put ETX on a first and a second packet boundary, just past one and just before one
  task automatic test_packet_boundary();
    send_frame(16'(LinkPacketBytes - 10), LinkPacketBytes - 10);
    send_frame(16'(2 * LinkPacketBytes - 10), 2 * LinkPacketBytes - 10);
    send_frame(16'(LinkPacketBytes - 8), LinkPacketBytes - 8);
    send_frame(16'(LinkPacketBytes - 11), LinkPacketBytes - 11);
  endtask

  task automatic test_backpressure();
    wait_idle();
    idle_on       = 1'b0;
    pop_hold_left = HoldCycles;
    send_frame(16'd40, 40);
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned phase_start;
    int unsigned pick;
    logic [15:0] len;
    phase_start = items_sent;
    while (items_sent < ItemTarget) begin
      if (items_sent - phase_start >= 60) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0:       write_limit(16'hFFFF);
          1:       write_limit(16'($urandom_range(1, 16)));
          2:       write_limit(16'($urandom_range(17, 200)));
          default: write_limit(16'($urandom_range(1, 65535)));
        endcase
        phase_start = items_sent;
      end
      idle_on = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 99);
      if (pick < 75) begin
        len = pick_length();
        send_frame(len, len);
      end else if (pick < 85) begin
        len = pick_length();
        send_frame(len, $urandom_range(0, len - 1));
      end else if (pick < 93) begin
        send_item(ReqStart, 16'($urandom), 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) send_item(ReqData, 16'($urandom), 8'($urandom));
      end
    end
    idle_on = 1'b1;
  endtask

  // result side: random stalls plus a long hold-off on request
  initial begin
    pop            = 1'b0;
    pop_hold_left  = 0;
    pop_stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (pop_hold_left > 0) begin
        pop <= 1'b0;
        pop_hold_left--;
      end else if (pop_stall_left > 0) begin
        pop <= 1'b0;
        pop_stall_left--;
      end else begin
        pop <= 1'b1;
        if (idle_on) begin
          pop_stall_left = pick_gap();
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: out_byte %0h last %0b", out_byte_o, last_o);
        errors++;
      end else begin
        next_expected = pending_results.pop_front();
        if (out_byte_o !== next_expected.out_byte) begin
          $error("out_byte: expected %0h, got %0h", next_expected.out_byte, out_byte_o);
          errors++;
        end
        if (packet_end_o !== next_expected.packet_end) begin
          $error("packet_end: expected %0b, got %0b", next_expected.packet_end,
                 packet_end_o);
          errors++;
        end
        if (empty_packet_o !== next_expected.empty_packet) begin
          $error("empty_packet: expected %0b, got %0b", next_expected.empty_packet,
                 empty_packet_o);
          errors++;
        end
        if (length_error_o !== next_expected.length_error) begin
          $error("length_error: expected %0b, got %0b", next_expected.length_error,
                 length_error_o);
          errors++;
        end
        if (last_o !== next_expected.last_flag) begin
          $error("last: expected %0b, got %0b", next_expected.last_flag, last_o);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    push           = 1'b0;
    req_type_i     = ReqStart;
    read_length_i  = '0;
    data_byte_i    = '0;
    errors         = 0;
    items_sent     = 0;
    idle_on        = 1'b1;
    read_limit     = MaxReadSizeReset;
    frame_active   = 1'b0;
    data_remaining = '0;
    frame_sum      = '0;
    link_fill      = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_length_limits();
    test_limit_extremes();
    test_packet_boundary();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
